/* rtl/s4a_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the SOCKS4a request parser.
package s4a_pkg;

    localparam logic [7:0] SOCKS_VER   = 8'h04;
    localparam logic [7:0] CMD_CONNECT = 8'h01;
    localparam logic [7:0] REP_GRANT   = 8'h5A;
    localparam logic [7:0] REP_FAIL    = 8'h5B;
    localparam logic [7:0] REP_NULL    = 8'h00;

    typedef enum logic [1:0] {
        KIND_USER   = 2'd0,
        KIND_DOMAIN = 2'd1,
        KIND_REPLY  = 2'd2
    } t_kind;

    // Per-word event from the parser to the output stage.
    typedef struct packed {
        logic       echo;        // accepted word is a name byte to echo
        t_kind      kind;        // user id or domain
        logic [7:0] data;        // echoed byte
        logic       reply_start; // final terminator seen
    } t_evt;

endpackage

/* rtl/s4a_parse.sv */
`timescale 1ns / 1ps
// Request field parser: phase tracking and captured header fields.
module s4a_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output s4a_pkg::t_evt o_evt,
    output logic [15:0]   o_port,
    output logic [31:0]   o_ip,
    output logic          o_granted,
    output logic          o_has_domain
);
    import s4a_pkg::*;

    typedef enum logic [3:0] {
        PH_VER, PH_CMD, PH_PORT_HI, PH_PORT_LO,
        PH_IP0, PH_IP1, PH_IP2, PH_IP3,
        PH_USER, PH_DOMAIN, PH_DONE
    } t_phase;

    t_phase      r_phase;
    logic [7:0]  r_ver;
    logic [7:0]  r_cmd;
    logic [15:0] r_port;
    logic [31:0] r_ip;
    logic        r_dom;

    logic        w_want_dom;

    // 0.0.0.x with x nonzero means a domain name follows the user id
    assign w_want_dom = (r_ip[31:8] == 24'd0) && (r_ip[7:0] != 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VER;
            r_ver   <= '0;
            r_cmd   <= '0;
            r_port  <= '0;
            r_ip    <= '0;
            r_dom   <= 1'b0;
        end else if (i_accept) begin
            case (r_phase)
                PH_VER: begin
                    r_ver   <= i_byte;
                    r_phase <= PH_CMD;
                end
                PH_CMD: begin
                    r_cmd   <= i_byte;
                    r_phase <= PH_PORT_HI;
                end
                PH_PORT_HI: begin
                    r_port[15:8] <= i_byte;
                    r_phase      <= PH_PORT_LO;
                end
                PH_PORT_LO: begin
                    r_port[7:0] <= i_byte;
                    r_phase     <= PH_IP0;
                end
                PH_IP0, PH_IP1, PH_IP2: begin
                    r_ip    <= {r_ip[23:0], i_byte};
                    r_phase <= t_phase'(r_phase + 4'd1);
                end
                PH_IP3: begin
                    r_ip    <= {r_ip[23:0], i_byte};
                    r_phase <= PH_USER;
                end
                PH_USER: begin
                    if (i_byte == 8'd0) begin
                        r_dom   <= w_want_dom;
                        r_phase <= w_want_dom ? PH_DOMAIN : PH_DONE;
                    end
                end
                PH_DOMAIN: begin
                    if (i_byte == 8'd0) begin
                        r_phase <= PH_DONE;
                    end
                end
                default: begin
                    r_phase <= PH_DONE;
                end
            endcase
        end
    end

    always_comb begin
        o_evt             = '0;
        o_evt.data        = i_byte;
        o_evt.kind        = (r_phase == PH_DOMAIN) ? KIND_DOMAIN : KIND_USER;
        if (i_accept) begin
            if (r_phase == PH_USER) begin
                o_evt.echo        = (i_byte != 8'd0);
                o_evt.reply_start = (i_byte == 8'd0) && !w_want_dom;
            end else if (r_phase == PH_DOMAIN) begin
                o_evt.echo        = (i_byte != 8'd0);
                o_evt.reply_start = (i_byte == 8'd0);
            end
        end
    end

    assign o_port       = r_port;
    assign o_ip         = r_ip;
    assign o_granted    = (r_ver == SOCKS_VER) && (r_cmd == CMD_CONNECT);
    assign o_has_domain = r_dom;

endmodule

/* rtl/s4a_out.sv */
`timescale 1ns / 1ps
// Output register and eight-byte reply sequencer.
module s4a_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  s4a_pkg::t_evt i_evt,
    input  logic [15:0]   i_port,
    input  logic [31:0]   i_ip,
    input  logic          i_granted,
    input  logic          i_has_domain,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_data,
    output logic          o_last,
    output logic [15:0]   o_port,
    output logic [31:0]   o_ip,
    output logic          o_granted,
    output logic          o_has_domain
);
    import s4a_pkg::*;

    logic        r_valid;
    logic        r_busy;
    logic [2:0]  r_idx;
    t_kind       r_kind;
    logic [7:0]  r_data;
    logic        r_last;
    logic [15:0] r_port;
    logic [31:0] r_ip;
    logic        r_granted;
    logic        r_has_dom;

    logic        w_free;
    logic [7:0]  w_rep_byte;

    assign w_free = !r_valid || i_ready;

    always_comb begin
        case (r_idx)
            3'd0:    w_rep_byte = REP_NULL;
            3'd1:    w_rep_byte = i_granted ? REP_GRANT : REP_FAIL;
            3'd2:    w_rep_byte = i_port[15:8];
            3'd3:    w_rep_byte = i_port[7:0];
            3'd4:    w_rep_byte = i_ip[31:24];
            3'd5:    w_rep_byte = i_ip[23:16];
            3'd6:    w_rep_byte = i_ip[15:8];
            default: w_rep_byte = i_ip[7:0];
        endcase
    end

    // echo and reply never compete: reply runs only after the parser is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_evt.reply_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
            if (w_free) begin
                r_valid <= i_evt.echo || r_busy;
                if (r_busy) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_port <= i_port;
            r_ip   <= i_ip;
            if (r_busy) begin
                r_kind    <= KIND_REPLY;
                r_data    <= w_rep_byte;
                r_last    <= (r_idx == 3'd7);
                r_granted <= i_granted;
                r_has_dom <= i_has_domain;
            end else begin
                r_kind    <= i_evt.kind;
                r_data    <= i_evt.data;
                r_last    <= 1'b0;
                r_granted <= 1'b0;
                r_has_dom <= 1'b0;
            end
        end
    end

    assign o_free       = w_free;
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_data       = r_data;
    assign o_last       = r_last;
    assign o_port       = r_port;
    assign o_ip         = r_ip;
    assign o_granted    = r_granted;
    assign o_has_domain = r_has_dom;

endmodule

/* rtl/socks4a_request_parser.sv */
`timescale 1ns / 1ps
// Top level of the SOCKS4a request parser.
//
// Takes one request byte per word on the slave stream: version, command, port
// (high byte first), four IP bytes, a zero-terminated user id and, only when
// the IP is 0.0.0.x with x nonzero, a zero-terminated domain. Name bytes are
// echoed one word each (tuser = user id or domain); terminators are not.
// On the final terminator the master stream carries the eight reply bytes
// 00, status (5A granted / 5B failed), port hi, port lo, IP[31:0] MSB first,
// tlast on the eighth, with granted and has_domain valid on those words.
// Afterwards input is accepted and dropped until reset. Throughput is one
// byte per cycle: parsing is a single state update per word and results go
// through one output register, so s_tready only drops when that register is
// full and the sink stalls. An echo word is presented the cycle after its byte
// is accepted. The reply sequencer arms on the terminator (r_busy is set), then
// loads the eight reply words into the output register in order, holding while
// the sink stalls; input keeps flowing meanwhile.
module socks4a_request_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [7:0] data, [23:8] dest_port,
                                     // [55:24] dest_ip, [56] granted,
                                     // [57] has_domain, [63:58] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last reply byte
);
    import s4a_pkg::*;

    logic        w_free;
    logic        w_accept;
    t_evt        w_evt;
    logic [15:0] w_port;
    logic [31:0] w_ip;
    logic        w_granted;
    logic        w_has_dom;

    logic [7:0]  w_data;
    logic [15:0] w_out_port;
    logic [31:0] w_out_ip;
    logic        w_out_granted;
    logic        w_out_dom;

    assign o_s_tready = w_free;
    assign w_accept   = i_s_tvalid && w_free;

    s4a_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_byte       (i_s_tdata),
        .o_evt        (w_evt),
        .o_port       (w_port),
        .o_ip         (w_ip),
        .o_granted    (w_granted),
        .o_has_domain (w_has_dom)
    );

    s4a_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (w_evt),
        .i_port       (w_port),
        .i_ip         (w_ip),
        .i_granted    (w_granted),
        .i_has_domain (w_has_dom),
        .o_free       (w_free),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kind       (o_m_tuser),
        .o_data       (w_data),
        .o_last       (o_m_tlast),
        .o_port       (w_out_port),
        .o_ip         (w_out_ip),
        .o_granted    (w_out_granted),
        .o_has_domain (w_out_dom)
    );

    assign o_m_tdata = {6'd0, w_out_dom, w_out_granted, w_out_ip, w_out_port, w_data};

endmodule
